>>> hdl/imu_ars_pkg.sv
// Shared widths, stage map, codes and types for the IMU axis remap/scale/saturate block.
// No dependencies; imported by every module under hdl/.
package imu_ars_pkg;

   localparam int NUM_AXES   = 3;
   localparam int SMP_W      = 16;
   localparam int SEL_W      = 2;
   localparam int SIGN_W     = 2;
   localparam int SCALE_W    = 16;
   localparam int VAL_W      = SMP_W + 2;          // sample times a sign of -2..1
   localparam int PROD_W     = VAL_W + SCALE_W;    // signed product
   localparam int DIV_BITS   = 32;                 // |product| <= 2^31
   localparam int REM_W      = 16;
   localparam int DVS_W      = 16;                 // |den| <= 2^15
   localparam int QUOT_W     = DIV_BITS + 1;
   localparam int SUM_W      = QUOT_W + 1;
   localparam int OFFS_W     = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // pipeline stage map
   localparam int STG_PROD = 0;
   localparam int STG_MAG  = 1;
   localparam int STG_DIV0 = 2;
   localparam int STG_QUOT = STG_DIV0 + DIV_BITS;
   localparam int STG_OUT  = STG_QUOT + 1;
   localparam int NUM_STG  = STG_OUT + 1;

   // source axis codes
   localparam logic [SEL_W-1:0] SRC_X    = 2'd0;
   localparam logic [SEL_W-1:0] SRC_Y    = 2'd1;
   localparam logic [SEL_W-1:0] SRC_Z    = 2'd2;
   localparam logic [SEL_W-1:0] SRC_SAME = 2'd3;

   // sign register codes (two's complement)
   localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
   localparam logic [SIGN_W-1:0] SIGN_NEG2 = 2'b10;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_SOURCES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIGN_X       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIGN_Y       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIGN_Z       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_NUM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_DEN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_OFFSETS = 3'd6;

   typedef logic signed [SMP_W-1:0]   smp_type;
   typedef logic signed [SIGN_W-1:0]  sign_type;
   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic [DIV_BITS-1:0]       mag_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;
   typedef logic [NUM_STG-1:0]        stg_en_type;
   typedef logic [STG_QUOT:0]         lane_en_type;
   typedef logic [DIV_BITS-1:0]       div_en_type;

   typedef struct packed {
      logic neg;   // quotient is negative
      logic dz;    // zero denominator
   } div_tag_type;

endpackage

>>> hdl/imu_ars_ctrl.sv
// Valid tracking and per-stage load enables for the elastic pipeline.
// Depends on imu_ars_pkg.
module imu_ars_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    rsp_stall,
   output logic                    req_stall,
   output logic                    rsp_valid,
   output imu_ars_pkg::stg_en_type stage_en
);
   import imu_ars_pkg::*;

   stg_en_type valid_ff;
   stg_en_type valid_in;

   // A stage may load when the output is free or this or any later stage holds a bubble.
   always_comb begin
      for (int i = 0; i < NUM_STG; i++) begin
         stage_en[i] = !rsp_stall || (|(~valid_ff >> i));
      end
      valid_in = {valid_ff[NUM_STG-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STG; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NUM_STG-1];

endmodule

>>> hdl/imu_ars_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on imu_ars_pkg.
module imu_ars_div (
   input  logic                     clock,
   input  imu_ars_pkg::div_en_type  stage_en,
   input  imu_ars_pkg::mag_type     dvd_i,
   input  logic [imu_ars_pkg::DVS_W-1:0] dvs_i,
   input  imu_ars_pkg::div_tag_type tag_i,
   output imu_ars_pkg::mag_type     quo_o,
   output imu_ars_pkg::div_tag_type tag_o
);
   import imu_ars_pkg::*;

   logic [REM_W-1:0] rem_ff  [DIV_BITS];
   mag_type          dvd_ff  [DIV_BITS];
   mag_type          quo_ff  [DIV_BITS];
   div_tag_type      tag_ff  [DIV_BITS];

   logic [REM_W-1:0] rem_src [DIV_BITS];
   mag_type          dvd_src [DIV_BITS];
   mag_type          quo_src [DIV_BITS];
   div_tag_type      tag_src [DIV_BITS];

   logic [REM_W:0]   trial   [DIV_BITS];
   logic [DIV_BITS-1:0] take;
   logic [REM_W-1:0] rem_in  [DIV_BITS];
   mag_type          dvd_in  [DIV_BITS];
   mag_type          quo_in  [DIV_BITS];

   always_comb begin
      rem_src[0] = '0;
      dvd_src[0] = dvd_i;
      quo_src[0] = '0;
      tag_src[0] = tag_i;
      for (int k = 1; k < DIV_BITS; k++) begin
         rem_src[k] = rem_ff[k-1];
         dvd_src[k] = dvd_ff[k-1];
         quo_src[k] = quo_ff[k-1];
         tag_src[k] = tag_ff[k-1];
      end
      for (int k = 0; k < DIV_BITS; k++) begin
         trial[k]  = {rem_src[k], dvd_src[k][DIV_BITS-1]};
         take[k]   = trial[k] >= {1'b0, dvs_i};
         // remainder stays below the divisor, so it fits REM_W
         rem_in[k] = take[k] ? REM_W'(trial[k] - {1'b0, dvs_i}) : REM_W'(trial[k]);
         dvd_in[k] = dvd_src[k] << 1;
         quo_in[k] = {quo_src[k][DIV_BITS-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_BITS; k++) begin
         if (stage_en[k]) begin
            rem_ff[k] <= rem_in[k];
            dvd_ff[k] <= dvd_in[k];
            quo_ff[k] <= quo_in[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign quo_o = quo_ff[DIV_BITS-1];
   assign tag_o = tag_ff[DIV_BITS-1];

endmodule

>>> hdl/imu_ars_lane.sv
// One output axis: source select, sign, scale multiply, divide, signed quotient.
// Depends on imu_ars_pkg and imu_ars_div.
module imu_ars_lane (
   input  logic                      clock,
   input  imu_ars_pkg::lane_en_type  stage_en,
   input  imu_ars_pkg::smp_type      smp_i [imu_ars_pkg::NUM_AXES],
   input  logic [imu_ars_pkg::SEL_W-1:0] src_sel,
   input  imu_ars_pkg::sign_type     sign_i,
   input  imu_ars_pkg::scale_type    num_i,
   input  imu_ars_pkg::scale_type    den_i,
   output imu_ars_pkg::quot_type     quot_o
);
   import imu_ars_pkg::*;

   smp_type                  src_val;
   logic signed [VAL_W-1:0]  val;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   mag_type                  mag_in;
   mag_type                  mag_ff;
   div_tag_type              tag_in;
   div_tag_type              tag_ff;
   logic [DVS_W-1:0]         dvs;
   mag_type                  quo;
   div_tag_type              quo_tag;
   quot_type                 quot_in;
   quot_type                 quot_ff;

   always_comb begin
      unique case (src_sel)
         SRC_X:   src_val = smp_i[0];
         SRC_Y:   src_val = smp_i[1];
         default: src_val = smp_i[2];
      endcase
      unique case (sign_i)
         SIGN_POS:  val = VAL_W'(src_val);
         SIGN_NEG:  val = -VAL_W'(src_val);
         SIGN_NEG2: val = -(VAL_W'(src_val) <<< 1);
         default:   val = '0;
      endcase
      prod_in = PROD_W'(val) * PROD_W'(num_i);

      mag_in     = prod_ff[PROD_W-1] ? DIV_BITS'(-prod_ff) : DIV_BITS'(prod_ff);
      tag_in.neg = prod_ff[PROD_W-1] ^ den_i[SCALE_W-1];
      tag_in.dz  = (den_i == '0);
      dvs        = den_i[SCALE_W-1] ? DVS_W'(-den_i) : DVS_W'(den_i);

      if (quo_tag.dz) begin
         quot_in = '0;
      end else if (quo_tag.neg) begin
         quot_in = -$signed({1'b0, quo});
      end else begin
         quot_in = $signed({1'b0, quo});
      end
   end

   imu_ars_div u_div (
      .clock    (clock),
      .stage_en (stage_en[STG_DIV0 +: DIV_BITS]),
      .dvd_i    (mag_ff),
      .dvs_i    (dvs),
      .tag_i    (tag_ff),
      .quo_o    (quo),
      .tag_o    (quo_tag)
   );

   always_ff @(posedge clock) begin
      if (stage_en[STG_PROD]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[STG_MAG]) begin
         mag_ff <= mag_in;
         tag_ff <= tag_in;
      end
      if (stage_en[STG_QUOT]) begin
         quot_ff <= quot_in;
      end
   end

   assign quot_o = quot_ff;

endmodule

>>> hdl/imu_axis_remap_scale_saturate_top.sv
// Top level: calibration registers, three axis lanes, offset/saturate merge stage.
// Depends on imu_ars_pkg, imu_ars_ctrl and imu_ars_lane.
//
// Calibrates one three-axis sample per beat: each output axis picks a source axis,
// applies its sign, scales by num/den (truncating toward zero, zero when den is 0),
// adds its offset and saturates to signed 16 bits. One beat is accepted every
// cycle unless stalled; it passes the 32-stage restoring divider in each lane
// plus multiply, magnitude, sign and output stages. The pipeline is elastic: empty
// stages keep filling while a result is held on a stalled output. Registers are to
// be written by the user only when no beat is in flight, which is not enforced.
module imu_axis_remap_scale_saturate_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [imu_ars_pkg::SMP_W-1:0]  req_in_x,
   input  logic signed [imu_ars_pkg::SMP_W-1:0]  req_in_y,
   input  logic signed [imu_ars_pkg::SMP_W-1:0]  req_in_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [imu_ars_pkg::SMP_W-1:0]  rsp_out_x,
   output logic signed [imu_ars_pkg::SMP_W-1:0]  rsp_out_y,
   output logic signed [imu_ars_pkg::SMP_W-1:0]  rsp_out_z,
   input  logic                                  csr_wr_en,
   input  logic [imu_ars_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imu_ars_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import imu_ars_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

   logic [NUM_AXES*SEL_W-1:0] axis_sources_ff;
   sign_type                  sign_x_ff;
   sign_type                  sign_y_ff;
   sign_type                  sign_z_ff;
   scale_type                 scale_num_ff;
   scale_type                 scale_den_ff;
   logic [OFFS_W-1:0]         axis_offsets_ff;

   stg_en_type    stage_en;
   smp_type       smp     [NUM_AXES];
   sign_type      signs   [NUM_AXES];
   quot_type      lane_quot [NUM_AXES];
   logic signed [SUM_W-1:0] sum [NUM_AXES];
   smp_type       out_in  [NUM_AXES];
   smp_type       out_ff  [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_sources_ff <= '1;
         sign_x_ff       <= SIGN_POS;
         sign_y_ff       <= SIGN_POS;
         sign_z_ff       <= SIGN_POS;
         scale_num_ff    <= SCALE_W'(1);
         scale_den_ff    <= SCALE_W'(1);
         axis_offsets_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_AXIS_SOURCES: axis_sources_ff <= csr_wdata[NUM_AXES*SEL_W-1:0];
            REG_SIGN_X:       sign_x_ff       <= csr_wdata[SIGN_W-1:0];
            REG_SIGN_Y:       sign_y_ff       <= csr_wdata[SIGN_W-1:0];
            REG_SIGN_Z:       sign_z_ff       <= csr_wdata[SIGN_W-1:0];
            REG_SCALE_NUM:    scale_num_ff    <= csr_wdata[SCALE_W-1:0];
            REG_SCALE_DEN:    scale_den_ff    <= csr_wdata[SCALE_W-1:0];
            REG_AXIS_OFFSETS: axis_offsets_ff <= csr_wdata[OFFS_W-1:0];
            default:          ;
         endcase
      end
   end

   imu_ars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .stage_en  (stage_en)
   );

   assign smp[0]   = req_in_x;
   assign smp[1]   = req_in_y;
   assign smp[2]   = req_in_z;
   assign signs[0] = sign_x_ff;
   assign signs[1] = sign_y_ff;
   assign signs[2] = sign_z_ff;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      logic [SEL_W-1:0] code;
      logic [SEL_W-1:0] src_sel;

      assign code    = axis_sources_ff[a*SEL_W +: SEL_W];
      assign src_sel = (code == SRC_SAME) ? SEL_W'(a) : code;

      imu_ars_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en[STG_QUOT:0]),
         .smp_i    (smp),
         .src_sel  (src_sel),
         .sign_i   (signs[a]),
         .num_i    (scale_num_ff),
         .den_i    (scale_den_ff),
         .quot_o   (lane_quot[a])
      );
   end

   // merge: offset add and saturation for all lanes into the output register
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sum[a] = SUM_W'(lane_quot[a])
                + SUM_W'($signed(axis_offsets_ff[a*SMP_W +: SMP_W]));
         if (sum[a] > SAT_HI) begin
            out_in[a] = SMP_W'(SAT_HI);
         end else if (sum[a] < SAT_LO) begin
            out_in[a] = SMP_W'(SAT_LO);
         end else begin
            out_in[a] = SMP_W'(sum[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_OUT]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            out_ff[a] <= out_in[a];
         end
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

endmodule

>>> dv/tb_top.sv
// Self-checking bench for imu_axis_remap_scale_saturate_top: directed and random calibrated
// triples, checked against an in-bench calculation. Depends on imu_ars_pkg and the RTL top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import imu_ars_pkg::*;

   localparam int PIPE_LATENCY  = NUM_STG;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 100;
   localparam int FLOOD_BEATS   = 80;
   localparam int SHOWN_ERRORS  = 10;
   localparam int SAT_MAX       = 32767;
   localparam int SAT_MIN       = -32768;
   // index 7 decodes to no register
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      smp_type x;
      smp_type y;
      smp_type z;
   } axis_triple_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   smp_type                req_in_x  = '0;
   smp_type                req_in_y  = '0;
   smp_type                req_in_z  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   smp_type                rsp_out_x;
   smp_type                rsp_out_y;
   smp_type                rsp_out_z;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the calibration registers, reset values
   logic [NUM_AXES*SEL_W-1:0] cal_sources = '1;
   sign_type                  cal_sign [NUM_AXES] = '{SIGN_POS, SIGN_POS, SIGN_POS};
   scale_type                 cal_num     = 16'sd1;
   scale_type                 cal_den     = 16'sd1;
   logic [OFFS_W-1:0]         cal_offsets = '0;

   axis_triple_type calibrated_q [$];
   int         error_count = 0;
   logic       idling      = 1'b1;
   logic       offering    = 1'b0;
   int         holds_asked = 0;
   int         holds_begun = 0;
   int         hold_cnt    = 0;
   int         stall_left  = 0;

   imu_axis_remap_scale_saturate_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in_x  (req_in_x),
      .req_in_y  (req_in_y),
      .req_in_z  (req_in_z),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic axis_triple_type calibrate_sample(input smp_type sx, input smp_type sy,
                                                        input smp_type sz);
      longint           raw [NUM_AXES];
      longint           v;
      longint           off;
      logic [SEL_W-1:0] code;
      int               src;
      smp_type          res [NUM_AXES];
      axis_triple_type  t;
      raw[0] = sx;
      raw[1] = sy;
      raw[2] = sz;
      for (int a = 0; a < NUM_AXES; a++) begin
         code = cal_sources[SEL_W*a +: SEL_W];
         src  = (code == SRC_SAME) ? a : int'(code);
         v    = raw[src] * longint'(cal_sign[a]);
         off  = longint'(smp_type'(cal_offsets[SMP_W*a +: SMP_W]));
         // SV signed division truncates toward zero
         v    = (cal_den != 0) ? (v * longint'(cal_num)) / longint'(cal_den) : 0;
         v    = v + off;
         if (v > SAT_MAX) v = SAT_MAX;
         else if (v < SAT_MIN) v = SAT_MIN;
         res[a] = smp_type'(v);
      end
      t.x = res[0];
      t.y = res[1];
      t.z = res[2];
      return t;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic smp_type pick_axis_value();
      int r;
      r = $urandom_range(0, 9);
      unique case (r)
         0: return smp_type'(SAT_MIN);
         1: return smp_type'(SAT_MAX);
         2: return smp_type'(int'($urandom_range(0, 8)) - 4);
         default: return smp_type'($urandom);
      endcase
   endfunction

   function automatic scale_type pick_scale();
      int r;
      r = $urandom_range(0, 9);
      unique case (r)
         0: return '0;
         1: return scale_type'(SAT_MIN);
         2: return scale_type'(SAT_MAX);
         3, 4: return scale_type'(int'($urandom_range(0, 16)) - 8);
         default: return scale_type'($urandom);
      endcase
   endfunction

   function automatic logic [OFFS_W-1:0] pick_offsets();
      smp_type ofs [NUM_AXES];
      int      r;
      for (int a = 0; a < NUM_AXES; a++) begin
         r = $urandom_range(0, 9);
         unique case (r)
            0: ofs[a] = smp_type'(SAT_MIN);
            1: ofs[a] = smp_type'(SAT_MAX);
            2, 3, 4: ofs[a] = smp_type'(int'($urandom_range(0, 400)) - 200);
            default: ofs[a] = smp_type'($urandom);
         endcase
      end
      return {ofs[2], ofs[1], ofs[0]};
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic compare_axis(input string name, input smp_type want, input smp_type got);
      if (got !== want) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   task automatic stop_offering();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Entered right after a rising edge; returns at the edge that accepted the beat.
   task automatic offer_sample(input smp_type sx, input smp_type sy, input smp_type sz);
      int gap;
      gap = idling ? idle_gap() : 0;
      if (gap > 0) begin
         stop_offering();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= sx;
      req_in_y  <= sy;
      req_in_z  <= sz;
      offering = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      calibrated_q.push_back(calibrate_sample(sx, sy, sz));
   endtask

   task automatic offer_random_samples(input int count);
      for (int i = 0; i < count; i++)
         offer_sample(pick_axis_value(), pick_axis_value(), pick_axis_value());
   endtask

   task automatic wait_for_drain();
      stop_offering();
      while (calibrated_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      unique case (idx)
         REG_AXIS_SOURCES: cal_sources = data[NUM_AXES*SEL_W-1:0];
         REG_SIGN_X:       cal_sign[0] = sign_type'(data[SIGN_W-1:0]);
         REG_SIGN_Y:       cal_sign[1] = sign_type'(data[SIGN_W-1:0]);
         REG_SIGN_Z:       cal_sign[2] = sign_type'(data[SIGN_W-1:0]);
         REG_SCALE_NUM:    cal_num     = scale_type'(data[SCALE_W-1:0]);
         REG_SCALE_DEN:    cal_den     = scale_type'(data[SCALE_W-1:0]);
         REG_AXIS_OFFSETS: cal_offsets = data[OFFS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // fill lands in the bits above each register's width and its inverse is written whole to
   // the unused index last, so a decode slip shows up in the next beats
   task automatic load_calibration(input logic [NUM_AXES*SEL_W-1:0] sources,
                                   input sign_type sgx, input sign_type sgy,
                                   input sign_type sgz, input scale_type num,
                                   input scale_type den, input logic [OFFS_W-1:0] offs,
                                   input logic [CSR_DATA_W-1:0] fill);
      wait_for_drain();
      write_reg(REG_AXIS_SOURCES, {fill[CSR_DATA_W-1:NUM_AXES*SEL_W], sources});
      write_reg(REG_SIGN_X, {fill[CSR_DATA_W-1:SIGN_W], sgx});
      write_reg(REG_SIGN_Y, {fill[CSR_DATA_W-1:SIGN_W], sgy});
      write_reg(REG_SIGN_Z, {fill[CSR_DATA_W-1:SIGN_W], sgz});
      write_reg(REG_SCALE_NUM, {fill[CSR_DATA_W-1:SCALE_W], num});
      write_reg(REG_SCALE_DEN, {fill[CSR_DATA_W-1:SCALE_W], den});
      write_reg(REG_AXIS_OFFSETS, offs);
      write_reg(REG_UNUSED, ~fill);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      offer_sample('0, '0, '0);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), -16'sd1);
      offer_sample(smp_type'(SAT_MIN), smp_type'(SAT_MAX), 16'sd1);
      offer_sample(16'sh5555, -16'sd1, 16'shAAAA);
   endtask

   task automatic test_remap_and_signs();
      // x from z, y from x, z keeps its own axis; signs -1, -2, 0
      load_calibration({SRC_SAME, SRC_X, SRC_Z}, SIGN_NEG, SIGN_NEG2, SIGN_ZERO,
                       16'sd1, 16'sd1, '0, '0);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), -16'sd1);
      offer_sample(smp_type'(SAT_MIN), smp_type'(SAT_MAX), 16'sd1);
      offer_sample(16'sd12345, -16'sd2222, 16'sd333);
      load_calibration({SRC_X, SRC_SAME, SRC_Y}, SIGN_POS, SIGN_POS, SIGN_NEG,
                       16'sd1, 16'sd1, '0, '0);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), -16'sd1);
      offer_sample(smp_type'(SAT_MIN), -16'sd7, smp_type'(SAT_MAX));
      offer_sample(-16'sd1000, 16'sd2000, -16'sd3000);
   endtask

   task automatic test_scale_and_saturation();
      // big negative gain, offsets at both rails: clamps high and low
      load_calibration({SRC_SAME, SRC_SAME, SRC_SAME}, SIGN_POS, SIGN_POS, SIGN_POS,
                       scale_type'(SAT_MIN), 16'sd1, {16'sd0, 16'sh8000, 16'sh7FFF}, '0);
      offer_sample(16'sd1, -16'sd1, '0);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), 16'sd3);
      offer_sample(-16'sd5, 16'sd5, '0);
      // zero denominator: output is the offset alone
      load_calibration({SRC_SAME, SRC_SAME, SRC_SAME}, SIGN_NEG2, SIGN_NEG, SIGN_POS,
                       scale_type'(SAT_MAX), '0, {16'sd1234, 16'sh7FFF, 16'sh8000}, '0);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), 16'sd7);
      offer_sample(smp_type'(SAT_MIN), smp_type'(SAT_MAX), -16'sd7);
      offer_sample('0, '0, '0);
      // widest product over the most negative denominator
      load_calibration({SRC_Z, SRC_Y, SRC_X}, SIGN_NEG2, SIGN_NEG2, SIGN_NEG2,
                       scale_type'(SAT_MIN), scale_type'(SAT_MIN), '0, '0);
      offer_sample(smp_type'(SAT_MIN), smp_type'(SAT_MAX), -16'sd1);
      offer_sample(smp_type'(SAT_MAX), smp_type'(SAT_MIN), 16'sd1);
      offer_sample(-16'sd3, 16'sd16384, -16'sd16385);
   endtask

   task automatic test_random_calibrations();
      logic [CSR_DATA_W-1:0] fill;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         fill   = {16'($urandom), 32'($urandom)};
         load_calibration((NUM_AXES*SEL_W)'($urandom),
                          sign_type'($urandom_range(0, 3)), sign_type'($urandom_range(0, 3)),
                          sign_type'($urandom_range(0, 3)), pick_scale(), pick_scale(),
                          pick_offsets(), fill);
         idling = (p % 3) != 2;
         offer_random_samples(PHASE_BEATS);
      end
      idling = 1'b1;
   endtask

   // receiver holds off long enough that the pipe fills and pushes back on the input
   task automatic test_backpressure();
      idling = 1'b0;
      holds_asked = holds_asked + 1;
      offer_random_samples(FLOOD_BEATS);
      idling = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= hold_cnt - 1;
      end else if (holds_begun != holds_asked) begin
         rsp_stall   <= 1'b1;
         hold_cnt    <= HOLD_CYCLES;
         holds_begun <= holds_begun + 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= idling ? idle_gap() : 0;
      end
   end

   always @(posedge clock) begin : beat_checker
      axis_triple_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (calibrated_q.size() == 0) begin
            flag_error($sformatf("result beat with nothing outstanding: %0d %0d %0d",
                                 rsp_out_x, rsp_out_y, rsp_out_z));
         end else begin
            want = calibrated_q.pop_front();
            compare_axis("out_x", want.x, rsp_out_x);
            compare_axis("out_y", want.y, rsp_out_y);
            compare_axis("out_z", want.z, rsp_out_z);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_remap_and_signs();
      test_scale_and_saturation();
      test_random_calibrations();
      test_backpressure();
      wait_for_drain();
      // catch any stray beats still coming out of the pipe
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (calibrated_q.size() != 0) flag_error("results still outstanding at end of run");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> imu_axis_remap_scale_saturate_top.f
hdl/imu_ars_pkg.sv
hdl/imu_ars_ctrl.sv
hdl/imu_ars_div.sv
hdl/imu_ars_lane.sv
hdl/imu_axis_remap_scale_saturate_top.sv
dv/tb_top.sv
